FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the receiver RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted (active-low reset).
`define FCR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define FCR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/fcr_pkg.sv
// ----------------------------------------------------------------------------
// fcr_pkg
// Types and constants of the framed command receiver.
// ----------------------------------------------------------------------------
package fcr_pkg;

    localparam int DATA_BYTES  = 8;   // usable frame data bytes, 1..8
    localparam int STORE_DEPTH = 8;   // physical data store entries
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int POS_W       = 4;
    localparam int NUM_REGS    = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] FRAME_FLAG = 8'h02;

    typedef enum logic [2:0] {
        REG_INDICATOR  = 3'd0,
        REG_RESET      = 3'd1,
        REG_CAN_CLEAR  = 3'd2,
        REG_CAN_ID_LO  = 3'd3,
        REG_CAN_ID_HI  = 3'd4,
        REG_CAN_SIZE   = 3'd5,
        REG_CAN_DATA   = 3'd6,
        REG_CAN_COMMIT = 3'd7
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_FLAG  = 2'd0,
        PH_EVENT = 2'd1,
        PH_VALUE = 2'd2,
        PH_CHECK = 2'd3
    } t_phase;

    typedef enum logic [3:0] {
        ACT_LAMP   = 4'd0,
        ACT_RESET  = 4'd1,
        ACT_CLEAR  = 4'd2,
        ACT_ID_LO  = 4'd3,
        ACT_ID_HI  = 4'd4,
        ACT_SIZE   = 4'd5,
        ACT_DATA   = 4'd6,
        ACT_COMMIT = 4'd7,
        ACT_NONE   = 4'd8
    } t_action;

    typedef struct packed {
        logic [7:0] event_code;
        logic [7:0] event_value;
        t_action    action;
    } t_cmd;

endpackage

FILE: hdl/fcr_rx_if.sv
// ----------------------------------------------------------------------------
// fcr_rx_if
// Received byte channel.
// ----------------------------------------------------------------------------
interface fcr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: hdl/fcr_res_if.sv
// ----------------------------------------------------------------------------
// fcr_res_if
// Result channel: one item per validated message.
// ----------------------------------------------------------------------------
interface fcr_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  event_code;
    logic [7:0]  event_value;
    logic        indicator_on;
    logic        reset_request;
    logic        frame_ready;
    logic [15:0] frame_id;
    logic [7:0]  frame_size;
    logic [63:0] frame_data;
    logic [3:0]  bytes_held;

    modport source (output valid, output event_code, output event_value,
                    output indicator_on, output reset_request, output frame_ready,
                    output frame_id, output frame_size, output frame_data,
                    output bytes_held, input ready);
    modport sink   (input valid, input event_code, input event_value,
                    input indicator_on, input reset_request, input frame_ready,
                    input frame_id, input frame_size, input frame_data,
                    input bytes_held, output ready);
endinterface

FILE: hdl/fcr_cfg_if.sv
// ----------------------------------------------------------------------------
// fcr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface fcr_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/fcr_front.sv
// ----------------------------------------------------------------------------
// fcr_front
// Byte parser: finds flag/event/value/checksum messages, checks the sum and
// classifies the event against the configured codes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcr_front
    import fcr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    fcr_rx_if.sink      i_rx,
    fcr_cfg_if.sink     i_cfg,
    input  logic        i_queue_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_event, n_event;
    logic [7:0] r_value, n_value;
    logic [7:0] r_codes [NUM_REGS];
    logic       accept;
    logic       sum_ok;
    t_action    action;

    assign i_cfg.ready = 1'b1;
    // Only the checksum byte may need a queue slot.
    assign i_rx.ready  = (r_phase != PH_CHECK) || !i_queue_full;
    assign accept      = i_rx.valid && i_rx.ready;
    assign sum_ok      = (8'(r_event + r_value) == i_rx.rx_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_codes[i] <= 8'(i);
            end
        end else if (i_cfg.valid && (i_cfg.index < 8'(NUM_REGS))) begin
            r_codes[i_cfg.index[2:0]] <= i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FLAG;
            r_event <= 8'd0;
            r_value <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_event <= n_event;
            r_value <= n_value;
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_event = r_event;
        n_value = r_value;
        o_push  = 1'b0;
        if (accept) begin
            unique case (r_phase)
                PH_FLAG: begin
                    if (i_rx.rx_byte == FRAME_FLAG) begin
                        n_phase = PH_EVENT;
                    end
                end
                PH_EVENT: begin
                    n_event = i_rx.rx_byte;
                    n_phase = PH_VALUE;
                end
                PH_VALUE: begin
                    n_value = i_rx.rx_byte;
                    n_phase = PH_CHECK;
                end
                PH_CHECK: begin
                    n_phase = PH_FLAG;
                    o_push  = sum_ok;
                end
                default: n_phase = PH_FLAG;
            endcase
        end
    end

    // First matching code in register order wins.
    always_comb begin
        if (r_event == r_codes[REG_INDICATOR]) begin
            action = ACT_LAMP;
        end else if (r_event == r_codes[REG_RESET]) begin
            action = ACT_RESET;
        end else if (r_event == r_codes[REG_CAN_CLEAR]) begin
            action = ACT_CLEAR;
        end else if (r_event == r_codes[REG_CAN_ID_LO]) begin
            action = ACT_ID_LO;
        end else if (r_event == r_codes[REG_CAN_ID_HI]) begin
            action = ACT_ID_HI;
        end else if (r_event == r_codes[REG_CAN_SIZE]) begin
            action = ACT_SIZE;
        end else if (r_event == r_codes[REG_CAN_DATA]) begin
            action = ACT_DATA;
        end else if (r_event == r_codes[REG_CAN_COMMIT]) begin
            action = ACT_COMMIT;
        end else begin
            action = ACT_NONE;
        end
    end

    assign o_cmd = '{event_code: r_event, event_value: r_value, action: action};

    `FCR_ASSERT(a_push_on_check, i_clk, i_rst_n, o_push |-> (r_phase == PH_CHECK && accept), "push outside checksum phase")
    `FCR_ASSERT(a_check_leaves, i_clk, i_rst_n, (accept && r_phase == PH_CHECK) |=> (r_phase == PH_FLAG), "checksum byte did not end the message")

endmodule

FILE: hdl/fcr_cmd_queue.sv
// ----------------------------------------------------------------------------
// fcr_cmd_queue
// Short command queue between parser and executor.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcr_cmd_queue
    import fcr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= QPTR_W'(r_wr_ptr + 1'b1);
            end
            if (do_pop) begin
                r_rd_ptr <= QPTR_W'(r_rd_ptr + 1'b1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= QCNT_W'(r_count + 1'b1);
                2'b01:   r_count <= QCNT_W'(r_count - 1'b1);
                default: r_count <= r_count;
            endcase
        end
    end

    `FCR_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full), "push into full queue")

endmodule

FILE: hdl/fcr_back.sv
// ----------------------------------------------------------------------------
// fcr_back
// Executor: applies lamp / reset / CAN frame commands and registers the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcr_back
    import fcr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    fcr_res_if.source  o_res
);

    logic             r_lamp, n_lamp;
    logic [15:0]      r_id, n_id;
    logic [7:0]       r_size, n_size;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [7:0]       r_store [STORE_DEPTH];
    logic [7:0]       n_store [STORE_DEPTH];
    logic             n_rst_req;
    logic             n_commit;
    logic [63:0]      n_data;

    logic             r_out_valid;
    logic [7:0]       r_out_code;
    logic [7:0]       r_out_value;
    logic             r_out_lamp;
    logic             r_out_rst;
    logic             r_out_commit;
    logic [15:0]      r_out_id;
    logic [7:0]       r_out_size;
    logic [63:0]      r_out_data;
    logic [POS_W-1:0] r_out_pos;

    assign o_pop = i_cmd_valid && (!r_out_valid || o_res.ready);

    always_comb begin
        n_lamp    = r_lamp;
        n_id      = r_id;
        n_size    = r_size;
        n_pos     = r_pos;
        n_store   = r_store;
        n_rst_req = 1'b0;
        n_commit  = 1'b0;
        case (i_cmd.action)
            ACT_LAMP:   n_lamp = (i_cmd.event_value != 8'd0);
            ACT_RESET:  n_rst_req = 1'b1;
            ACT_CLEAR: begin
                n_id  = 16'd0;
                n_pos = '0;
            end
            ACT_ID_LO:  n_id = r_id | {8'd0, i_cmd.event_value};
            ACT_ID_HI:  n_id = r_id | {i_cmd.event_value, 8'd0};
            ACT_SIZE:   n_size = i_cmd.event_value;
            ACT_DATA: begin
                // full buffer drops the byte
                if (r_pos < POS_W'(DATA_BYTES)) begin
                    n_store[r_pos[IDX_W-1:0]] = i_cmd.event_value;
                    n_pos = POS_W'(r_pos + 1'b1);
                end
            end
            ACT_COMMIT: n_commit = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        n_data = '0;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            if (i < DATA_BYTES) begin
                n_data[8*i +: 8] = n_store[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lamp <= 1'b0;
            r_id   <= 16'd0;
            r_size <= 8'd0;
            r_pos  <= '0;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_store[i] <= 8'd0;
            end
        end else if (o_pop) begin
            r_lamp  <= n_lamp;
            r_id    <= n_id;
            r_size  <= n_size;
            r_pos   <= n_pos;
            r_store <= n_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_code   <= i_cmd.event_code;
            r_out_value  <= i_cmd.event_value;
            r_out_lamp   <= n_lamp;
            r_out_rst    <= n_rst_req;
            r_out_commit <= n_commit;
            r_out_id     <= n_id;
            r_out_size   <= n_size;
            r_out_data   <= n_data;
            r_out_pos    <= n_pos;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.event_code    = r_out_code;
    assign o_res.event_value   = r_out_value;
    assign o_res.indicator_on  = r_out_lamp;
    assign o_res.reset_request = r_out_rst;
    assign o_res.frame_ready   = r_out_commit;
    assign o_res.frame_id      = r_out_id;
    assign o_res.frame_size    = r_out_size;
    assign o_res.frame_data    = r_out_data;
    assign o_res.bytes_held    = r_out_pos;

    `FCR_ASSERT(a_pos_bound, i_clk, i_rst_n, r_pos <= POS_W'(DATA_BYTES), "data position past buffer")
    `FCR_ASSERT(a_flags_exclusive, i_clk, i_rst_n, r_out_valid |-> !(r_out_rst && r_out_commit), "reset and commit in one item")

endmodule

FILE: hdl/framed_command_receiver_unit.sv
// ----------------------------------------------------------------------------
// framed_command_receiver_unit
// Framed command receiver: serial bytes in, validated command results out.
// ----------------------------------------------------------------------------
// One received byte is taken per clock, except while a checksum byte stalls.
// Messages are flag 0x02, event, value and checksum (event + value mod 256);
// each message whose checksum matches produces one result item, the state
// after its lamp, reset or CAN frame action, if any. The parser places a
// matched command in a two-entry queue on the checksum byte; the executor
// pops it when its output register is empty or being taken, applies it and
// holds the result in that output register. The byte channel stalls only on
// a checksum byte while the queue is full; other bytes are always taken.
// Configuration writes are taken every cycle; indexes past the last code
// register are dropped.

module framed_command_receiver_unit
    import fcr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    fcr_rx_if.sink     i_rx,
    fcr_cfg_if.sink    i_cfg,
    fcr_res_if.source  o_res
);

    logic queue_full;
    logic push;
    t_cmd push_cmd;
    logic cmd_valid;
    logic pop;
    t_cmd head_cmd;

    fcr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx         (i_rx),
        .i_cfg        (i_cfg),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    fcr_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (queue_full),
        .o_valid (cmd_valid),
        .i_pop   (pop),
        .o_cmd   (head_cmd)
    );

    fcr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .o_res       (o_res)
    );

endmodule

FILE: test/tb_framed_command_receiver_unit.sv
// ----------------------------------------------------------------------------
// tb_framed_command_receiver_unit
// Self-checking bench for the framed command receiver.
// ----------------------------------------------------------------------------
// Bytes are streamed in bursts while the result side stalls on its own
// pattern. A behavioral parser tracks each accepted byte and queues the
// result of every message whose checksum matches. Each result item is
// compared field by field against the oldest queued one. Code registers are
// reloaded between phases: defaults, extremes, colliding codes and random
// codes. One phase holds the result side off long enough to fill the block.
// ----------------------------------------------------------------------------

module tb_framed_command_receiver_unit;
    import fcr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam logic [7:0]  IDX_PAST_END  = 8'(NUM_REGS);
    localparam logic [7:0]  IDX_TOP       = 8'hFF;

    typedef logic [7:0] t_code_set [NUM_REGS];

    typedef struct {
        logic [7:0]  code;
        logic [7:0]  value;
        logic        lamp;
        logic        rst_req;
        logic        commit;
        logic [15:0] id;
        logic [7:0]  size;
        logic [63:0] data;
        logic [3:0]  held;
    } t_cmd_result;

    logic i_clk;
    logic i_rst_n;

    fcr_rx_if  rx_if();
    fcr_cfg_if cfg_if();
    fcr_res_if res_if();

    framed_command_receiver_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // Parser copy: code registers, message phase and CAN frame state
    logic [7:0]  code_reg [NUM_REGS];
    t_phase      rx_phase;
    logic [7:0]  ev_hold;
    logic [7:0]  val_hold;
    logic [15:0] frame_id_acc;
    logic [7:0]  frame_size_acc;
    logic [3:0]  data_pos;
    logic [7:0]  data_bytes [STORE_DEPTH];
    logic        lamp_lit;

    t_cmd_result validated_msgs [$];

    t_code_set   active_codes;
    int unsigned bytes_sent     = 0;
    int unsigned msgs_sent      = 0;
    int unsigned results_seen   = 0;
    int unsigned settings_used  = 1;
    int unsigned failures       = 0;
    int unsigned cycle_count    = 0;
    int unsigned burst_left     = 0;
    int unsigned hold_request   = 0;
    bit          gaps_on        = 1'b1;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d results outstanding", $time,
                     validated_msgs.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic void clear_model();
        for (int i = 0; i < NUM_REGS; i++) code_reg[i] = 8'(i);
        for (int i = 0; i < STORE_DEPTH; i++) data_bytes[i] = 8'h00;
        rx_phase       = PH_FLAG;
        ev_hold        = 8'h00;
        val_hold       = 8'h00;
        frame_id_acc   = 16'h0000;
        frame_size_acc = 8'h00;
        data_pos       = 4'd0;
        lamp_lit       = 1'b0;
    endfunction

    function automatic void parse_rx_byte(logic [7:0] b);
        t_cmd_result r;
        t_action     act;
        case (rx_phase)
            PH_FLAG: begin
                if (b == FRAME_FLAG) rx_phase = PH_EVENT;
                return;
            end
            PH_EVENT: begin
                ev_hold  = b;
                rx_phase = PH_VALUE;
                return;
            end
            PH_VALUE: begin
                val_hold = b;
                rx_phase = PH_CHECK;
                return;
            end
            default: begin
                rx_phase = PH_FLAG;
                if (8'(ev_hold + val_hold) != b) return;
            end
        endcase

        // lowest register index wins when codes collide
        act = ACT_NONE;
        for (int i = NUM_REGS - 1; i >= 0; i--) begin
            if (ev_hold == code_reg[i]) act = t_action'(i);
        end

        r.rst_req = 1'b0;
        r.commit  = 1'b0;
        case (act)
            ACT_LAMP:   lamp_lit = (val_hold != 8'h00);
            ACT_RESET:  r.rst_req = 1'b1;
            ACT_CLEAR: begin
                frame_id_acc = 16'h0000;
                data_pos     = 4'd0;
            end
            ACT_ID_LO:  frame_id_acc |= {8'h00, val_hold};
            ACT_ID_HI:  frame_id_acc |= {val_hold, 8'h00};
            ACT_SIZE:   frame_size_acc = val_hold;
            ACT_DATA: begin
                if (data_pos < DATA_BYTES) begin
                    data_bytes[data_pos[IDX_W-1:0]] = val_hold;
                    data_pos++;
                end
            end
            ACT_COMMIT: r.commit = 1'b1;
            default: ;
        endcase

        r.code  = ev_hold;
        r.value = val_hold;
        r.lamp  = lamp_lit;
        r.id    = frame_id_acc;
        r.size  = frame_size_acc;
        r.held  = data_pos;
        r.data  = 64'h0;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            if (i < DATA_BYTES) r.data[8*i +: 8] = data_bytes[i];
        end
        validated_msgs.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (cfg_if.valid && cfg_if.ready && cfg_if.index < NUM_REGS)
                code_reg[cfg_if.index[IDX_W-1:0]] = cfg_if.data;
            if (rx_if.valid && rx_if.ready)
                parse_rx_byte(rx_if.rx_byte);
        end
    end

    function automatic void match_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            failures++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_cmd_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            results_seen++;
            if (validated_msgs.size() == 0) begin
                failures++;
                $display("%0t: result with no message pending, expected none, actual event %0h",
                         $time, res_if.event_code);
            end else begin
                want = validated_msgs.pop_front();
                match_field("event_code",    want.code,    res_if.event_code);
                match_field("event_value",   want.value,   res_if.event_value);
                match_field("indicator_on",  want.lamp,    res_if.indicator_on);
                match_field("reset_request", want.rst_req, res_if.reset_request);
                match_field("frame_ready",   want.commit,  res_if.frame_ready);
                match_field("frame_id",      want.id,      res_if.frame_id);
                match_field("frame_size",    want.size,    res_if.frame_size);
                match_field("frame_data",    want.data,    res_if.frame_data);
                match_field("bytes_held",    want.held,    res_if.bytes_held);
            end
        end
    end

    // Result side: changes stall pattern every so often; a hold request
    // forces a long stretch with ready low.
    initial begin : result_sink
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            if (hold_left != 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                case (mode)
                    0:       res_if.ready <= 1'b1;
                    1:       res_if.ready <= ($urandom_range(0, 3) != 0);
                    2:       res_if.ready <= 1'($urandom_range(0, 1));
                    default: res_if.ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    // Called just after the clock rises; returns once the byte is taken.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = gaps_on ? $urandom_range(0, 8) : 0;
            if (gap != 0) begin
                rx_if.valid   <= 1'b0;
                rx_if.rx_byte <= 8'($urandom);
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!rx_if.ready);
        bytes_sent++;
    endtask

    task automatic send_msg(input logic [7:0] ev, input logic [7:0] val, input bit good);
        logic [7:0] sum;
        sum = ev + val;
        send_byte(FRAME_FLAG);
        send_byte(ev);
        send_byte(val);
        send_byte(good ? sum : sum ^ 8'($urandom_range(1, 255)));
        msgs_sent++;
    endtask

    function automatic logic [7:0] pick_event();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r >= 12) return 8'($urandom);
        if (r >= 8) return active_codes[REG_CAN_DATA];
        return active_codes[r[IDX_W-1:0]];
    endfunction

    function automatic logic [7:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r < 3) return 8'h00;
        if (r < 5) return 8'hFF;
        return 8'($urandom);
    endfunction

    // Drop valid, let every pending result drain, then let the block settle,
    // since bad-checksum messages leave nothing to wait on.
    task automatic wait_idle();
        rx_if.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (validated_msgs.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_codes(input t_code_set codes, input bit poke_beyond);
        wait_idle();
        if (poke_beyond) begin
            // writes past the last code register must be dropped
            cfg_if.valid <= 1'b1;
            cfg_if.index <= IDX_PAST_END;
            cfg_if.data  <= 8'($urandom);
            do @(posedge i_clk); while (!cfg_if.ready);
            cfg_if.index <= IDX_TOP;
            cfg_if.data  <= 8'($urandom);
            do @(posedge i_clk); while (!cfg_if.ready);
        end
        for (int i = 0; i < NUM_REGS; i++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= 8'(i);
            cfg_if.data  <= codes[i];
            do @(posedge i_clk); while (!cfg_if.ready);
        end
        cfg_if.valid <= 1'b0;
        active_codes = codes;
        settings_used++;
    endtask

    // Runs right after reset, so the default codes are in force.
    task automatic test_default_codes();
        send_byte(8'hFF);                                    // stray byte before any flag
        send_msg(active_codes[REG_INDICATOR],  8'hFF, 1'b1);
        send_msg(active_codes[REG_RESET],      8'h00, 1'b1);
        send_msg(active_codes[REG_CAN_ID_LO],  8'hFF, 1'b1);
        send_msg(active_codes[REG_CAN_ID_HI],  8'h80, 1'b1);
        send_msg(active_codes[REG_CAN_SIZE],   8'hFF, 1'b1);
        send_msg(active_codes[REG_CAN_DATA],   8'hA5, 1'b1);
        send_msg(active_codes[REG_CAN_COMMIT], 8'h01, 1'b1);
        send_msg(active_codes[REG_CAN_CLEAR],  8'h7E, 1'b1); // data and size survive
        send_msg(8'hFF, 8'hFF, 1'b1);                        // no code matches
        // bad check byte equal to the flag must not start a new message
        send_byte(FRAME_FLAG);
        send_byte(active_codes[REG_INDICATOR]);
        send_byte(8'h55);
        send_byte(FRAME_FLAG);
        send_msg(active_codes[REG_INDICATOR], 8'h00, 1'b1);  // lamp off
    endtask

    task automatic run_random_messages(input int unsigned n_bytes);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                send_msg(pick_event(), pick_value(), 1'b1);
            end else if (pick < 85) begin
                send_msg(pick_event(), pick_value(), 1'b0);
            end else if (pick < 93) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
            end else begin
                // truncated message, the following bytes complete it somehow
                send_byte(FRAME_FLAG);
                repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
            end
        end
    endtask

    task automatic test_output_backpressure();
        gaps_on      = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (16) send_msg(pick_event(), pick_value(), 1'b1);
        gaps_on = 1'b1;
    endtask

    initial begin
        t_code_set rnd_codes;
        i_rst_n       <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= 8'h00;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= 8'h00;
        cfg_if.data   <= 8'h00;
        for (int i = 0; i < NUM_REGS; i++) active_codes[i] = 8'(i);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_codes();
        run_random_messages(180);

        load_codes('{8'hFF, 8'h00, 8'h80, 8'h7F, 8'h02, 8'h55, 8'hAA, 8'h01}, 1'b1);
        run_random_messages(180);

        // every code on the flag value: the indicator takes all of them
        load_codes('{FRAME_FLAG, FRAME_FLAG, FRAME_FLAG, FRAME_FLAG,
                     FRAME_FLAG, FRAME_FLAG, FRAME_FLAG, FRAME_FLAG}, 1'b0);
        run_random_messages(100);

        // pairwise collisions: earlier register shadows the later one
        load_codes('{8'h10, 8'h10, 8'h20, 8'h20, 8'h30, 8'h30, 8'h40, 8'h40}, 1'b0);
        run_random_messages(150);

        load_codes('{8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07}, 1'b0);
        test_output_backpressure();

        for (int i = 0; i < NUM_REGS; i++) rnd_codes[i] = 8'($urandom);
        load_codes(rnd_codes, 1'b1);
        run_random_messages(300);

        wait_idle();
        $display("Sent %0d bytes (%0d framed messages) over %0d code settings;",
                 bytes_sent, msgs_sent, settings_used);
        $display("checked %0d result items, %0d field mismatches.", results_seen, failures);
        if (failures == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
